FILE: hw/rtl/bcomp_pkg.sv
package bcomp_pkg;

  // pipeline depth: 1 prepare, 5 divide, 11 polynomial
  localparam int NSTG     = 17;
  localparam int DIV_STG  = 5;
  localparam int DIV_STEP = 7;
  localparam int NUM_W    = 35;   // dividend width, DIV_STG * DIV_STEP
  localparam int MAG_W    = 30;   // magnitude of a scaled sample

  localparam logic signed [31:0] Q32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;
  localparam logic [2:0]         P_SEL_RST = 3'd7;
  localparam logic [2:0]         T_SEL_RST = 3'd0;

  typedef enum logic [2:0] {
    REG_CALIB_A = 3'd0,
    REG_CALIB_B = 3'd1,
    REG_CALIB_C = 3'd2,
    REG_P_SEL   = 3'd3,
    REG_T_SEL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [NSTG-1:0] ld;   // stage load enables, bit 0 is the entry stage
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coef_t;

  // Scale factors are (2^(sel+1)-1) * 2^19 for sel 0..3 and
  // (2^(sel+1)-1) * 2^13 for sel 4..7, so raw*2^24/k = (raw << shift) / d.
  function automatic logic [7:0] scale_div(input logic [2:0] sel);
    logic [8:0] p;
    p = 9'd1 << ({1'b0, sel} + 4'd1);
    return 8'(p - 9'd1);
  endfunction

  function automatic logic [3:0] scale_shift(input logic [2:0] sel);
    return sel[2] ? 4'd11 : 4'd5;
  endfunction

endpackage

FILE: hw/rtl/bcomp_if.sv
interface bcomp_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bcomp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_q16;
  logic signed [31:0] pressure_q8;
  logic               saturated;
  modport source (output valid, temperature_q16, pressure_q8, saturated, input ready);
  modport sink   (input valid, temperature_q16, pressure_q8, saturated, output ready);
endinterface

interface bcomp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bcomp_cfg_regs.sv
module bcomp_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  bcomp_cfg_if.sink           cfg,
  output bcomp_pkg::coef_t    coef,
  output logic [2:0]          p_sel,
  output logic [2:0]          t_sel
);

  logic [47:0] ca_r, cb_r, cc_r;
  logic [2:0]  psel_r, tsel_r;

  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r   <= '0;
      cb_r   <= '0;
      cc_r   <= '0;
      psel_r <= bcomp_pkg::P_SEL_RST;
      tsel_r <= bcomp_pkg::T_SEL_RST;
    end else if (cfg.valid) begin
      case (bcomp_pkg::reg_idx_t'(cfg.index))
        bcomp_pkg::REG_CALIB_A: ca_r   <= cfg.data;
        bcomp_pkg::REG_CALIB_B: cb_r   <= cfg.data;
        bcomp_pkg::REG_CALIB_C: cc_r   <= cfg.data;
        bcomp_pkg::REG_P_SEL:   psel_r <= cfg.data[2:0];
        bcomp_pkg::REG_T_SEL:   tsel_r <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  // coefficient unpacking, byte 0 in the top bits
  assign coef.c0  = ca_r[47:36];
  assign coef.c1  = ca_r[35:24];
  assign coef.c00 = ca_r[23:4];
  assign coef.c10 = {ca_r[3:0], cb_r[47:32]};
  assign coef.c01 = cb_r[31:16];
  assign coef.c11 = cb_r[15:0];
  assign coef.c20 = cc_r[47:32];
  assign coef.c21 = cc_r[31:16];
  assign coef.c30 = cc_r[15:0];

  assign p_sel = psel_r;
  assign t_sel = tsel_r;

endmodule

FILE: hw/rtl/bcomp_scale.sv
module bcomp_scale (
  input  logic                      clk,
  input  bcomp_pkg::pipe_ctl_t      ctl,
  input  logic [23:0]               raw_p,
  input  logic [23:0]               raw_t,
  input  logic [2:0]                p_sel,
  input  logic [2:0]                t_sel,
  output logic [bcomp_pkg::MAG_W-1:0] p_mag,
  output logic [bcomp_pkg::MAG_W-1:0] t_mag,
  output logic                      p_neg,
  output logic                      t_neg
);

  localparam int NW = bcomp_pkg::NUM_W;

  // lane 0 pressure, lane 1 temperature; index 0 is the entry stage
  logic [NW-1:0] wrk_r   [0:bcomp_pkg::DIV_STG][0:1];
  logic [7:0]    rem_r   [0:bcomp_pkg::DIV_STG][0:1];
  logic [7:0]    d_r     [0:bcomp_pkg::DIV_STG][0:1];
  logic          n_r     [0:bcomp_pkg::DIV_STG][0:1];
  logic [NW-1:0] wrk_nxt [1:bcomp_pkg::DIV_STG][0:1];
  logic [7:0]    rem_nxt [1:bcomp_pkg::DIV_STG][0:1];
  logic [NW-1:0] a_nxt   [0:1];
  logic [7:0]    d_nxt   [0:1];
  logic [23:0]   raw     [0:1];
  logic [2:0]    sel     [0:1];

  assign raw[0] = raw_p;
  assign raw[1] = raw_t;
  assign sel[0] = p_sel;
  assign sel[1] = t_sel;

  // entry: magnitude, shift and half-divisor for rounding
  always_comb begin
    logic [23:0] mag;
    for (int l = 0; l < 2; l++) begin
      mag      = raw[l][23] ? 24'(~raw[l] + 24'd1) : raw[l];
      d_nxt[l] = bcomp_pkg::scale_div(sel[l]);
      a_nxt[l] = ({11'd0, mag} << bcomp_pkg::scale_shift(sel[l]))
                 + {27'd0, 1'b0, d_nxt[l][7:1]};
    end
  end

  // restoring division, several quotient bits per stage
  always_comb begin
    logic [7:0]    rem_t;
    logic [NW-1:0] wrk_t;
    logic [8:0]    rem9;
    for (int l = 0; l < 2; l++) begin
      for (int k = 1; k <= bcomp_pkg::DIV_STG; k++) begin
        rem_t = rem_r[k-1][l];
        wrk_t = wrk_r[k-1][l];
        for (int j = 0; j < bcomp_pkg::DIV_STEP; j++) begin
          rem9  = {rem_t, wrk_t[NW-1]};
          wrk_t = {wrk_t[NW-2:0], 1'b0};
          if (rem9 >= {1'b0, d_r[k-1][l]}) begin
            rem9     = rem9 - {1'b0, d_r[k-1][l]};
            wrk_t[0] = 1'b1;
          end
          rem_t = rem9[7:0];
        end
        rem_nxt[k][l] = rem_t;
        wrk_nxt[k][l] = wrk_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (ctl.ld[0]) begin
        wrk_r[0][l] <= a_nxt[l];
        rem_r[0][l] <= '0;
        d_r[0][l]   <= d_nxt[l];
        n_r[0][l]   <= raw[l][23];
      end
      for (int k = 1; k <= bcomp_pkg::DIV_STG; k++) begin
        if (ctl.ld[k]) begin
          wrk_r[k][l] <= wrk_nxt[k][l];
          rem_r[k][l] <= rem_nxt[k][l];
          d_r[k][l]   <= d_r[k-1][l];
          n_r[k][l]   <= n_r[k-1][l];
        end
      end
    end
  end

  assign p_mag = wrk_r[bcomp_pkg::DIV_STG][0][bcomp_pkg::MAG_W-1:0];
  assign t_mag = wrk_r[bcomp_pkg::DIV_STG][1][bcomp_pkg::MAG_W-1:0];
  assign p_neg = n_r[bcomp_pkg::DIV_STG][0];
  assign t_neg = n_r[bcomp_pkg::DIV_STG][1];

endmodule

FILE: hw/rtl/bcomp_poly.sv
module bcomp_poly (
  input  logic                        clk,
  input  bcomp_pkg::pipe_ctl_t        ctl,
  input  bcomp_pkg::coef_t            coef,
  input  logic [bcomp_pkg::MAG_W-1:0] p_mag,
  input  logic [bcomp_pkg::MAG_W-1:0] t_mag,
  input  logic                        p_neg,
  input  logic                        t_neg,
  output logic signed [31:0]          temperature_q16,
  output logic signed [31:0]          pressure_q8,
  output logic                        saturated
);

  localparam int MW = bcomp_pkg::MAG_W;

  // sample magnitudes and signs carried down to the second product
  logic [MW-1:0] pm_r [7:12];
  logic [MW-1:0] tm_r [7:12];
  logic          pn_r [7:12];
  logic          tn_r [7:12];
  // temperature result carried to the output
  logic signed [31:0] tq_r   [9:17];
  logic               tsat_r [9:17];

  // S7: signed samples, first products
  logic signed [MW:0]  psc_c, tsc_c;
  logic signed [45:0]  pr30_c, pr21_c, pr30_r, pr21_r;
  logic signed [41:0]  t1_c, t24_c, t24_r;

  assign psc_c  = p_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
  assign tsc_c  = t_neg ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
  assign pr30_c = coef.c30 * psc_c;
  assign pr21_c = coef.c21 * psc_c;
  assign t1_c   = coef.c1 * tsc_c;
  assign t24_c  = (42'(coef.c0) <<< 23) + t1_c;

  // S8: inner Horner sums as sign and magnitude; temperature rounding
  logic signed [45:0] acc1_c, tacc1_c;
  logic [44:0]        am1_c, tam1_c, am1_r, tam1_r;
  logic               an1_r, tan1_r;
  logic [41:0]        tmag_c;
  logic [33:0]        tr_c;
  logic signed [34:0] t16_c, t16_r;

  assign acc1_c  = (46'(coef.c20) <<< 24) + pr30_r;
  assign tacc1_c = (46'(coef.c11) <<< 24) + pr21_r;
  assign am1_c   = acc1_c[45]  ? 45'(-acc1_c)  : 45'(acc1_c);
  assign tam1_c  = tacc1_c[45] ? 45'(-tacc1_c) : 45'(tacc1_c);
  assign tmag_c  = t24_r[41] ? 42'(-t24_r) : 42'(t24_r);
  assign tr_c    = 34'(({1'b0, tmag_c} + 43'd128) >> 8);
  assign t16_c   = t24_r[41] ? -$signed({1'b0, tr_c}) : $signed({1'b0, tr_c});

  // S9: partial products against Psc; temperature clamp
  logic [42:0] ph1_r, tph1_r;
  logic [61:0] pl1_r, tpl1_r;
  logic        an1_9_r, tan1_9_r;
  logic signed [31:0] tq_c;
  logic               tsat_c;

  always_comb begin
    tsat_c = 1'b1;
    if (t16_r > 35'(bcomp_pkg::Q32_MAX)) tq_c = bcomp_pkg::Q32_MAX;
    else if (t16_r < 35'(bcomp_pkg::Q32_MIN)) tq_c = bcomp_pkg::Q32_MIN;
    else begin
      tq_c   = t16_r[31:0];
      tsat_c = 1'b0;
    end
  end

  // S10: rounded Q24 product magnitudes
  logic [62:0] ls1_c, tls1_c;
  logic [50:0] r1_c, tr1_c, r1_r, tr1_r;
  logic        an1_10_r, tan1_10_r;

  assign ls1_c  = {1'b0, pl1_r}  + 63'h80_0000;
  assign tls1_c = {1'b0, tpl1_r} + 63'h80_0000;
  assign r1_c   = {ph1_r, 8'd0}  + 51'(ls1_c[62:24]);
  assign tr1_c  = {tph1_r, 8'd0} + 51'(tls1_c[62:24]);

  // S11: outer Horner sums
  logic signed [51:0] r1s_c, tr1s_c, acc2_c, tacc2_c, acc2_r, tacc2_r;

  assign r1s_c   = an1_10_r  ? -$signed({1'b0, r1_r})  : $signed({1'b0, r1_r});
  assign tr1s_c  = tan1_10_r ? -$signed({1'b0, tr1_r}) : $signed({1'b0, tr1_r});
  assign acc2_c  = (52'(coef.c10) <<< 24) + r1s_c;
  assign tacc2_c = (52'(coef.c01) <<< 24) + tr1s_c;

  // S12: sign and magnitude for the last products
  logic [50:0] am2_r, tam2_r;
  logic        an2_r, tan2_r;

  // S13: partial products, pressure term by Psc, temperature term by Tsc
  logic [48:0] ph2_r, tph2_r;
  logic [61:0] pl2_r, tpl2_r;
  logic        an2_13_r, tan2_13_r;

  // S14: rounded term magnitudes
  logic [62:0] ls2_c, tls2_c;
  logic [56:0] r2_c, tr2_c, r2_r, tr2_r;
  logic        an2_14_r, tan2_14_r;

  assign ls2_c  = {1'b0, pl2_r}  + 63'h80_0000;
  assign tls2_c = {1'b0, tpl2_r} + 63'h80_0000;
  assign r2_c   = {ph2_r, 8'd0}  + 57'(ls2_c[62:24]);
  assign tr2_c  = {tph2_r, 8'd0} + 57'(tls2_c[62:24]);

  // S15: full pressure sum in Q24
  logic signed [57:0] pt_c, tt_c, p24_c, p24_r;

  assign pt_c  = an2_14_r  ? -$signed({1'b0, r2_r})  : $signed({1'b0, r2_r});
  assign tt_c  = tan2_14_r ? -$signed({1'b0, tr2_r}) : $signed({1'b0, tr2_r});
  assign p24_c = (58'(coef.c00) <<< 24) + pt_c + tt_c;

  // S16: round to Q8
  logic [56:0]        pmag_c;
  logic [41:0]        pr_c;
  logic signed [42:0] p8_c, p8_r;

  assign pmag_c = p24_r[57] ? 57'(-p24_r) : 57'(p24_r);
  assign pr_c   = 42'(({1'b0, pmag_c} + 58'd32768) >> 16);
  assign p8_c   = p24_r[57] ? -$signed({1'b0, pr_c}) : $signed({1'b0, pr_c});

  // S17: pressure clamp into the output register
  logic signed [31:0] pq_c, pq_r;
  logic               psat_c, sat_r;

  always_comb begin
    psat_c = 1'b1;
    if (p8_r > 43'(bcomp_pkg::Q32_MAX)) pq_c = bcomp_pkg::Q32_MAX;
    else if (p8_r < 43'(bcomp_pkg::Q32_MIN)) pq_c = bcomp_pkg::Q32_MIN;
    else begin
      pq_c   = p8_r[31:0];
      psat_c = 1'b0;
    end
  end

  // stage registers, each loads on its own enable
  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      pm_r[7] <= p_mag;
      tm_r[7] <= t_mag;
      pn_r[7] <= p_neg;
      tn_r[7] <= t_neg;
      pr30_r  <= pr30_c;
      pr21_r  <= pr21_c;
      t24_r   <= t24_c;
    end
    for (int s = 8; s <= 12; s++) begin
      if (ctl.ld[s-1]) begin
        pm_r[s] <= pm_r[s-1];
        tm_r[s] <= tm_r[s-1];
        pn_r[s] <= pn_r[s-1];
        tn_r[s] <= tn_r[s-1];
      end
    end
    if (ctl.ld[7]) begin
      am1_r  <= am1_c;
      tam1_r <= tam1_c;
      an1_r  <= acc1_c[45] ^ pn_r[7];
      tan1_r <= tacc1_c[45] ^ pn_r[7];
      t16_r  <= t16_c;
    end
    if (ctl.ld[8]) begin
      ph1_r     <= am1_r[44:32]  * pm_r[8];
      pl1_r     <= am1_r[31:0]   * pm_r[8];
      tph1_r    <= tam1_r[44:32] * pm_r[8];
      tpl1_r    <= tam1_r[31:0]  * pm_r[8];
      an1_9_r   <= an1_r;
      tan1_9_r  <= tan1_r;
      tq_r[9]   <= tq_c;
      tsat_r[9] <= tsat_c;
    end
    for (int s = 10; s <= 17; s++) begin
      if (ctl.ld[s-1]) begin
        tq_r[s]   <= tq_r[s-1];
        tsat_r[s] <= tsat_r[s-1];
      end
    end
    if (ctl.ld[9]) begin
      r1_r      <= r1_c;
      tr1_r     <= tr1_c;
      an1_10_r  <= an1_9_r;
      tan1_10_r <= tan1_9_r;
    end
    if (ctl.ld[10]) begin
      acc2_r  <= acc2_c;
      tacc2_r <= tacc2_c;
    end
    if (ctl.ld[11]) begin
      am2_r  <= acc2_r[51]  ? 51'(-acc2_r)  : 51'(acc2_r);
      tam2_r <= tacc2_r[51] ? 51'(-tacc2_r) : 51'(tacc2_r);
      an2_r  <= acc2_r[51]  ^ pn_r[11];
      tan2_r <= tacc2_r[51] ^ tn_r[11];
    end
    if (ctl.ld[12]) begin
      ph2_r     <= am2_r[50:32]  * pm_r[12];
      pl2_r     <= am2_r[31:0]   * pm_r[12];
      tph2_r    <= tam2_r[50:32] * tm_r[12];
      tpl2_r    <= tam2_r[31:0]  * tm_r[12];
      an2_13_r  <= an2_r;
      tan2_13_r <= tan2_r;
    end
    if (ctl.ld[13]) begin
      r2_r      <= r2_c;
      tr2_r     <= tr2_c;
      an2_14_r  <= an2_13_r;
      tan2_14_r <= tan2_13_r;
    end
    if (ctl.ld[14]) p24_r <= p24_c;
    if (ctl.ld[15]) p8_r  <= p8_c;
    if (ctl.ld[16]) begin
      pq_r  <= pq_c;
      sat_r <= psat_c | tsat_r[16];
    end
  end

  assign temperature_q16 = tq_r[17];
  assign pressure_q8     = pq_r;
  assign saturated       = sat_r;

endmodule

FILE: hw/rtl/barometer_compensation.sv
// Barometer compensation: turns one raw pressure / raw temperature pair into
// compensated temperature (Q15.16 degC) and pressure (Q23.8 Pa), both clipped
// to 32 bits, with a flag when either was clipped.
// Channels: in_ch takes a beat of two 24-bit two's complement samples,
// out_ch gives one result beat for each input beat, in order. cfg_ch writes
// the calibration bytes and the two oversampling selects; it is always ready.
// The user must write it only while no item is in flight; no check is made.
// Pipeline: one prepare stage, five stages of a restoring divider (seven
// quotient bits each) for the scale factors, eleven stages of multiplies and
// sums for the polynomial. Throughput: one item per cycle while out_ch is
// ready, set by the fully pipelined datapath.
// Stall: each stage holds its beat while the stage after it is full and held,
// empty stages still fill, so in_ch.ready drops only once all 17 stages hold beats.
// Reset: all stages empty, calibration bytes zero, pressure select 7,
// temperature select 0.
module barometer_compensation (
  input  logic         clk,
  input  logic         rst_n,
  bcomp_in_if.sink     in_ch,
  bcomp_out_if.source  out_ch,
  bcomp_cfg_if.sink    cfg_ch
);

  localparam int NSTG = bcomp_pkg::NSTG;

  bcomp_pkg::coef_t     coef;
  bcomp_pkg::pipe_ctl_t ctl;
  logic [2:0]           p_sel, t_sel;
  logic [NSTG-1:0]      v_r, ld;
  logic [bcomp_pkg::MAG_W-1:0] p_mag, t_mag;
  logic                 p_neg, t_neg;

  // load enables ripple back from the output
  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int s = NSTG - 2; s >= 0; s--) ld[s] = !v_r[s] || ld[s+1];
  end

  assign ctl.ld      = ld;
  assign in_ch.ready = ld[0];
  assign out_ch.valid = v_r[NSTG-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_ch.valid;
      for (int s = 1; s < NSTG; s++) begin
        if (ld[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  bcomp_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .coef  (coef),
    .p_sel (p_sel),
    .t_sel (t_sel)
  );

  bcomp_scale u_scale (
    .clk   (clk),
    .ctl   (ctl),
    .raw_p (in_ch.raw_pressure),
    .raw_t (in_ch.raw_temperature),
    .p_sel (p_sel),
    .t_sel (t_sel),
    .p_mag (p_mag),
    .t_mag (t_mag),
    .p_neg (p_neg),
    .t_neg (t_neg)
  );

  bcomp_poly u_poly (
    .clk             (clk),
    .ctl             (ctl),
    .coef            (coef),
    .p_mag           (p_mag),
    .t_mag           (t_mag),
    .p_neg           (p_neg),
    .t_neg           (t_neg),
    .temperature_q16 (out_ch.temperature_q16),
    .pressure_q8     (out_ch.pressure_q8),
    .saturated       (out_ch.saturated)
  );

  // input held off only when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input blocked with an empty stage");

  // output drains when nothing is behind it
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !v_r[NSTG-2] |=> !out_ch.valid)
    else $error("result repeated after hand-over");

  // a clip flag always comes with a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (out_ch.temperature_q16 == bcomp_pkg::Q32_MAX ||
       out_ch.temperature_q16 == bcomp_pkg::Q32_MIN ||
       out_ch.pressure_q8 == bcomp_pkg::Q32_MAX ||
       out_ch.pressure_q8 == bcomp_pkg::Q32_MIN))
    else $error("clip flag without a rail value");

endmodule
